@@ design/cnoc_pkg.sv @@
// cnoc_pkg: shared types and codes for the chromosome name order comparator
// used by cnoc_scan, cnoc_result and the top level; depends on nothing
package cnoc_pkg;

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_RUNS,
        PH_BY_FIRST,
        PH_BY_NUMBER
    } phase_t;

    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // control part of the state as it stands after a final item
    typedef struct packed {
        phase_t     phase;
        logic [1:0] first_order;
        logic       overflowed;
    } final_t;

endpackage

@@ design/cnoc_digit_acc.sv @@
// cnoc_digit_acc: one decimal step n*10 + digit with saturation at all ones
// depends on cnoc_pkg for the digit code
module cnoc_digit_acc #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic [NUMBER_WIDTH-1:0] number,
    input  logic [7:0]              digit_char,
    output logic [NUMBER_WIDTH-1:0] sum,
    output logic                    sat
);

    localparam int WideWidth = NUMBER_WIDTH + 4;

    logic [WideWidth-1:0] wide;
    logic [3:0]           digit_val;

    always_comb
    begin
        digit_val = 4'(digit_char - cnoc_pkg::CHAR_ZERO);
        // 10n = 8n + 2n, no multiplier needed
        wide = ({4'b0000, number} << 3) + ({4'b0000, number} << 1)
               + {{(WideWidth-4){1'b0}}, digit_val};
        // anything above the number width means the range was exceeded
        sat = |wide[WideWidth-1:NUMBER_WIDTH];
        sum = sat ? {NUMBER_WIDTH{1'b1}} : wide[NUMBER_WIDTH-1:0];
    end

endmodule

@@ design/cnoc_scan.sv @@
// cnoc_scan: per-item state update (prefix scan, digit runs) and final snapshot
// depends on cnoc_pkg and cnoc_digit_acc
module cnoc_scan #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic [7:0]              byte_a,
    input  logic [7:0]              byte_b,
    input  logic                    last,
    output cnoc_pkg::final_t        snap,
    output logic [NUMBER_WIDTH-1:0] snap_number_a,
    output logic [NUMBER_WIDTH-1:0] snap_number_b
);

    cnoc_pkg::phase_t        phase_reg, phase_next;
    logic [NUMBER_WIDTH-1:0] number_a_reg, number_a_next;
    logic [NUMBER_WIDTH-1:0] number_b_reg, number_b_next;
    logic                    live_a_reg, live_a_next;
    logic                    live_b_reg, live_b_next;
    logic                    ends_a_reg, ends_a_next;
    logic                    ends_b_reg, ends_b_next;
    logic [1:0]              first_order_reg, first_order_next;
    logic                    overflowed_reg, overflowed_next;

    cnoc_pkg::final_t        snap_reg;
    logic [NUMBER_WIDTH-1:0] snap_a_reg, snap_b_reg;

    logic [NUMBER_WIDTH-1:0] acc_in_a, acc_in_b, acc_sum_a, acc_sum_b;
    logic                    acc_sat_a, acc_sat_b;
    logic                    digit_a, digit_b;

    // a run starts from zero at the first differing pair
    assign acc_in_a = (phase_reg == cnoc_pkg::PH_PREFIX) ? '0 : number_a_reg;
    assign acc_in_b = (phase_reg == cnoc_pkg::PH_PREFIX) ? '0 : number_b_reg;

    cnoc_digit_acc #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_acc_a (
        .number     (acc_in_a),
        .digit_char (byte_a),
        .sum        (acc_sum_a),
        .sat        (acc_sat_a)
    );

    cnoc_digit_acc #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_acc_b (
        .number     (acc_in_b),
        .digit_char (byte_b),
        .sum        (acc_sum_b),
        .sat        (acc_sat_b)
    );

    assign digit_a = byte_a inside {[cnoc_pkg::CHAR_ZERO:cnoc_pkg::CHAR_NINE]};
    assign digit_b = byte_b inside {[cnoc_pkg::CHAR_ZERO:cnoc_pkg::CHAR_NINE]};

    always_comb
    begin
        phase_next       = phase_reg;
        number_a_next    = number_a_reg;
        number_b_next    = number_b_reg;
        live_a_next      = live_a_reg;
        live_b_next      = live_b_reg;
        ends_a_next      = ends_a_reg;
        ends_b_next      = ends_b_reg;
        first_order_next = first_order_reg;
        overflowed_next  = overflowed_reg;

        case (phase_reg)
            cnoc_pkg::PH_PREFIX:
            begin
                if (byte_a != byte_b || byte_a == cnoc_pkg::CHAR_NUL)
                begin
                    if (byte_a < byte_b)
                        first_order_next = cnoc_pkg::ORD_LESS;
                    else if (byte_a > byte_b)
                        first_order_next = cnoc_pkg::ORD_GREATER;
                    else
                        first_order_next = cnoc_pkg::ORD_EQUAL;
                    if (digit_a && digit_b)
                    begin
                        number_a_next = acc_sum_a;
                        number_b_next = acc_sum_b;
                        live_a_next   = 1'b1;
                        live_b_next   = 1'b1;
                        phase_next    = cnoc_pkg::PH_RUNS;
                    end
                    else
                    begin
                        phase_next = cnoc_pkg::PH_BY_FIRST;
                    end
                end
            end
            cnoc_pkg::PH_RUNS:
            begin
                if (live_a_reg)
                begin
                    if (digit_a)
                    begin
                        number_a_next = acc_sum_a;
                        if (acc_sat_a)
                            overflowed_next = 1'b1;
                    end
                    else
                    begin
                        live_a_next = 1'b0;
                        ends_a_next = (byte_a == cnoc_pkg::CHAR_NUL);
                    end
                end
                if (live_b_reg)
                begin
                    if (digit_b)
                    begin
                        number_b_next = acc_sum_b;
                        if (acc_sat_b)
                            overflowed_next = 1'b1;
                    end
                    else
                    begin
                        live_b_next = 1'b0;
                        ends_b_next = (byte_b == cnoc_pkg::CHAR_NUL);
                    end
                end
                if (!live_a_next && !live_b_next)
                    phase_next = (ends_a_next && ends_b_next) ? cnoc_pkg::PH_BY_NUMBER
                                                              : cnoc_pkg::PH_BY_FIRST;
            end
            default:
            begin
                // decided: bytes ignored until the final item
            end
        endcase

        // end of stream closes any run still open, also one begun on this item
        if (last && phase_next == cnoc_pkg::PH_RUNS)
        begin
            if (live_a_next)
            begin
                live_a_next = 1'b0;
                ends_a_next = 1'b1;
            end
            if (live_b_next)
            begin
                live_b_next = 1'b0;
                ends_b_next = 1'b1;
            end
            phase_next = (ends_a_next && ends_b_next) ? cnoc_pkg::PH_BY_NUMBER
                                                      : cnoc_pkg::PH_BY_FIRST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= cnoc_pkg::PH_PREFIX;
            number_a_reg    <= '0;
            number_b_reg    <= '0;
            live_a_reg      <= 1'b0;
            live_b_reg      <= 1'b0;
            ends_a_reg      <= 1'b0;
            ends_b_reg      <= 1'b0;
            first_order_reg <= cnoc_pkg::ORD_EQUAL;
            overflowed_reg  <= 1'b0;
        end
        else if (advance)
        begin
            if (last)
            begin
                phase_reg       <= cnoc_pkg::PH_PREFIX;
                number_a_reg    <= '0;
                number_b_reg    <= '0;
                live_a_reg      <= 1'b0;
                live_b_reg      <= 1'b0;
                ends_a_reg      <= 1'b0;
                ends_b_reg      <= 1'b0;
                first_order_reg <= cnoc_pkg::ORD_EQUAL;
                overflowed_reg  <= 1'b0;
            end
            else
            begin
                phase_reg       <= phase_next;
                number_a_reg    <= number_a_next;
                number_b_reg    <= number_b_next;
                live_a_reg      <= live_a_next;
                live_b_reg      <= live_b_next;
                ends_a_reg      <= ends_a_next;
                ends_b_reg      <= ends_b_next;
                first_order_reg <= first_order_next;
                overflowed_reg  <= overflowed_next;
            end
        end
    end

    // snapshot payload, loaded only on a final item
    always_ff @(posedge clk)
    begin
        if (advance && last)
        begin
            snap_reg.phase       <= phase_next;
            snap_reg.first_order <= first_order_next;
            snap_reg.overflowed  <= overflowed_next;
            snap_a_reg           <= number_a_next;
            snap_b_reg           <= number_b_next;
        end
    end

    assign snap          = snap_reg;
    assign snap_number_a = snap_a_reg;
    assign snap_number_b = snap_b_reg;

endmodule

@@ design/cnoc_result.sv @@
// cnoc_result: turns a final snapshot into the result fields and registers them
// depends on cnoc_pkg
module cnoc_result #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    load,
    input  cnoc_pkg::final_t        snap,
    input  logic [NUMBER_WIDTH-1:0] number_a,
    input  logic [NUMBER_WIDTH-1:0] number_b,
    output logic [1:0]              order,
    output logic                    by_number,
    output logic                    saturated
);

    logic [1:0] order_reg, order_next;
    logic       by_number_reg, by_number_next;
    logic       saturated_reg;

    always_comb
    begin
        order_next     = cnoc_pkg::ORD_EQUAL;
        by_number_next = 1'b0;
        case (snap.phase)
            cnoc_pkg::PH_BY_NUMBER:
            begin
                by_number_next = 1'b1;
                if (number_a < number_b)
                    order_next = cnoc_pkg::ORD_LESS;
                else if (number_a > number_b)
                    order_next = cnoc_pkg::ORD_GREATER;
                else
                    order_next = cnoc_pkg::ORD_EQUAL;
            end
            cnoc_pkg::PH_BY_FIRST:
                order_next = snap.first_order;
            default:
                order_next = cnoc_pkg::ORD_EQUAL;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            order_reg     <= order_next;
            by_number_reg <= by_number_next;
            saturated_reg <= snap.overflowed;
        end
    end

    assign order     = order_reg;
    assign by_number = by_number_reg;
    assign saturated = saturated_reg;

endmodule

@@ design/chrom_name_order_compare.sv @@
// chrom_name_order_compare: top level of the chromosome name order comparator
// depends on cnoc_pkg, cnoc_scan (with cnoc_digit_acc) and cnoc_result
//
//  channel  dir  tdata fields (low bit up)                  tlast
//  s_axis   in   byte_a[7:0], byte_b[15:8]                  last
//  m_axis   out  order[1:0], by_number[2], saturated[3]     -
//
// one byte pair is taken every cycle unless a final item is held back; a result
// leaves through the input register, snapshot register and result register
// the state update is one decimal step and compare per side, the number
// compare sits alone between the snapshot and the result register
// rst_n clears the valid bits and the scan state at once
// a stalled result holds only the snapshot stage behind it; pairs that are
// not final keep flowing until a second final item would need that stage
module chrom_name_order_compare #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // byte_a[7:0], byte_b[15:8]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // order[1:0], by_number[2], saturated[3]
);

    logic             in_valid_reg;
    logic [7:0]       in_a_reg, in_b_reg;
    logic             in_last_reg;
    logic             snap_valid_reg;
    logic             out_valid_reg;

    logic             in_move, snap_move, snap_free;
    logic             s_accept;

    cnoc_pkg::final_t        snap;
    logic [NUMBER_WIDTH-1:0] snap_number_a, snap_number_b;
    logic [1:0]              order;
    logic                    by_number, saturated;

    assign snap_move     = snap_valid_reg && (!out_valid_reg || m_axis_tready);
    assign snap_free     = !snap_valid_reg || snap_move;
    assign in_move       = in_valid_reg && (!in_last_reg || snap_free);
    assign s_axis_tready = !in_valid_reg || in_move;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (snap_free)
                snap_valid_reg <= in_move && in_last_reg;
            if (!out_valid_reg || m_axis_tready)
                out_valid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_a_reg    <= s_axis_tdata[7:0];
            in_b_reg    <= s_axis_tdata[15:8];
            in_last_reg <= s_axis_tlast;
        end
    end

    cnoc_scan #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (in_move),
        .byte_a        (in_a_reg),
        .byte_b        (in_b_reg),
        .last          (in_last_reg),
        .snap          (snap),
        .snap_number_a (snap_number_a),
        .snap_number_b (snap_number_b)
    );

    cnoc_result #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_result (
        .clk       (clk),
        .load      (snap_move),
        .snap      (snap),
        .number_a  (snap_number_a),
        .number_b  (snap_number_b),
        .order     (order),
        .by_number (by_number),
        .saturated (saturated)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, saturated, by_number, order};

endmodule

@@ bench/cnoc_tb_pkg.sv @@
// cnoc_tb_pkg: name order scoreboard for the chromosome name comparator bench
// predicts the order result of every compared name pair; depends on cnoc_pkg
package cnoc_tb_pkg;

    typedef logic [7:0] byte_q_t [$];

    // laid out as the low nibble of m_axis_tdata
    typedef struct packed {
        logic       saturated;
        logic       by_number;
        logic [1:0] order;
    } order_result_t;

    class name_order_board;

        logic [63:0]      num_max;
        cnoc_pkg::phase_t scan_phase;
        logic [63:0]      number [2];
        logic             run_live [2];
        logic             ends_name [2];
        logic [1:0]       first_ord;
        logic             overflowed;

        order_result_t pending_orders [$];
        int            mismatches;
        int            compared;
        int            numeric_seen;
        int            saturated_seen;

        function new(int width);
            num_max = {64{1'b1}} >> (64 - width);
            mismatches = 0;
            compared = 0;
            numeric_seen = 0;
            saturated_seen = 0;
            clear();
        endfunction

        function void clear();
            scan_phase = cnoc_pkg::PH_PREFIX;
            first_ord = cnoc_pkg::ORD_EQUAL;
            overflowed = 1'b0;
            for (int s = 0; s < 2; s++)
            begin
                number[s] = '0;
                run_live[s] = 1'b0;
                ends_name[s] = 1'b0;
            end
        endfunction

        function logic is_digit(logic [7:0] c);
            return c >= cnoc_pkg::CHAR_ZERO && c <= cnoc_pkg::CHAR_NINE;
        endfunction

        function logic [63:0] accumulate(logic [63:0] n, logic [7:0] c);
            logic [63:0] d;
            d = {56'd0, c} - {56'd0, cnoc_pkg::CHAR_ZERO};
            if (n > (num_max - d) / 10)
            begin
                overflowed = 1'b1;
                return num_max;
            end
            return n * 10 + d;
        endfunction

        function logic [1:0] order_of(logic [63:0] x, logic [63:0] y);
            if (x < y)
                return cnoc_pkg::ORD_LESS;
            if (x > y)
                return cnoc_pkg::ORD_GREATER;
            return cnoc_pkg::ORD_EQUAL;
        endfunction

        function void run_byte(int s, logic [7:0] c);
            if (!run_live[s])
                return;
            if (is_digit(c))
                number[s] = accumulate(number[s], c);
            else
            begin
                run_live[s] = 1'b0;
                ends_name[s] = (c == cnoc_pkg::CHAR_NUL);
            end
        endfunction

        function void settle_runs();
            if (run_live[0] || run_live[1])
                return;
            scan_phase = (ends_name[0] && ends_name[1]) ? cnoc_pkg::PH_BY_NUMBER
                                                        : cnoc_pkg::PH_BY_FIRST;
        endfunction

        function void take_pair(logic [7:0] a, logic [7:0] b, logic fin);
            order_result_t r;
            case (scan_phase)
                cnoc_pkg::PH_PREFIX:
                begin
                    if (a != b || a == cnoc_pkg::CHAR_NUL)
                    begin
                        first_ord = order_of({56'd0, a}, {56'd0, b});
                        if (is_digit(a) && is_digit(b))
                        begin
                            number[0] = accumulate('0, a);
                            number[1] = accumulate('0, b);
                            run_live[0] = 1'b1;
                            run_live[1] = 1'b1;
                            scan_phase = cnoc_pkg::PH_RUNS;
                        end
                        else
                            scan_phase = cnoc_pkg::PH_BY_FIRST;
                    end
                end
                cnoc_pkg::PH_RUNS:
                begin
                    run_byte(0, a);
                    run_byte(1, b);
                    settle_runs();
                end
                default: ;
            endcase
            if (!fin)
                return;
            // stream end closes any digit run still open
            if (scan_phase == cnoc_pkg::PH_RUNS)
            begin
                for (int s = 0; s < 2; s++)
                begin
                    if (run_live[s])
                    begin
                        run_live[s] = 1'b0;
                        ends_name[s] = 1'b1;
                    end
                end
                settle_runs();
            end
            r.saturated = overflowed;
            r.by_number = 1'b0;
            r.order = cnoc_pkg::ORD_EQUAL;
            if (scan_phase == cnoc_pkg::PH_BY_NUMBER)
            begin
                r.order = order_of(number[0], number[1]);
                r.by_number = 1'b1;
            end
            else if (scan_phase == cnoc_pkg::PH_BY_FIRST)
                r.order = first_ord;
            pending_orders.push_back(r);
            compared++;
            numeric_seen += r.by_number;
            saturated_seen += r.saturated;
            clear();
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void check_order(logic [7:0] word);
            order_result_t want;
            order_result_t got;
            got = order_result_t'(word[3:0]);
            if (pending_orders.size() == 0)
            begin
                flag($sformatf("result %b arrived with no comparison pending", word));
                return;
            end
            want = pending_orders.pop_front();
            if (got.order !== want.order || got.by_number !== want.by_number ||
                got.saturated !== want.saturated)
                flag($sformatf("order %0d/%0d by_number %0b/%0b saturated %0b/%0b (exp/act)",
                               want.order, got.order, want.by_number, got.by_number,
                               want.saturated, got.saturated));
        endfunction

    endclass

endpackage

@@ bench/tb_chrom_name_order_compare.sv @@
// tb_chrom_name_order_compare: self-checking bench for the name order comparator
// streams byte pairs with random gaps and stalls; depends on cnoc_pkg, cnoc_tb_pkg
module tb_chrom_name_order_compare;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUMBER_WIDTH   = 32;
    localparam int ITEM_TARGET    = 700;
    localparam int IDLE_LIMIT     = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AT_RESULT = 15;
    localparam int DRAIN_CYCLES   = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tready = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [7:0]  m_axis_tdata;

    cnoc_tb_pkg::name_order_board board = new(NUMBER_WIDTH);
    int          pairs_sent = 0;
    int          idle_cycles = 0;
    logic        tx_calm = 1'b0;

    always #5 clk = ~clk;

    chrom_name_order_compare #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.take_pair(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                board.check_order(m_axis_tdata);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stalls, calm stretches and one long hold-off
    initial
    begin
        int   got;
        int   stall;
        logic calm;
        got = 0;
        calm = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 8);
            if (got == HOLD_AT_RESULT)
                stall = HOLD_CYCLES;
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            got++;
        end
    end

    task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic fin);
        int gap;
        if ($urandom_range(0, 31) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, a};
        s_axis_tlast <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pairs_sent++;
    endtask

    // names padded with nul to equal length, optional terminator pair, then junk
    task automatic send_names(input cnoc_tb_pkg::byte_q_t na, input cnoc_tb_pkg::byte_q_t nb,
                              input logic terminate, input int junk);
        int         n;
        logic [7:0] a;
        logic [7:0] b;
        n = (na.size() > nb.size()) ? na.size() : nb.size();
        for (int i = 0; i < n; i++)
        begin
            a = (i < na.size()) ? na[i] : cnoc_pkg::CHAR_NUL;
            b = (i < nb.size()) ? nb[i] : cnoc_pkg::CHAR_NUL;
            send_pair(a, b, !terminate && junk == 0 && i == n - 1);
        end
        if (terminate)
            send_pair(cnoc_pkg::CHAR_NUL, cnoc_pkg::CHAR_NUL, junk == 0);
        for (int j = 0; j < junk; j++)
        begin
            a = ($urandom_range(0, 3) == 0) ? cnoc_pkg::CHAR_ZERO + 8'($urandom_range(0, 9))
                                             : 8'($urandom_range(0, 255));
            b = ($urandom_range(0, 3) == 0) ? cnoc_pkg::CHAR_ZERO + 8'($urandom_range(0, 9))
                                             : 8'($urandom_range(0, 255));
            send_pair(a, b, j == junk - 1);
        end
    endtask

    function automatic cnoc_tb_pkg::byte_q_t text(string s);
        cnoc_tb_pkg::byte_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    function automatic cnoc_tb_pkg::byte_q_t join_bytes(cnoc_tb_pkg::byte_q_t x,
                                                        cnoc_tb_pkg::byte_q_t y);
        cnoc_tb_pkg::byte_q_t q;
        q = x;
        foreach (y[i])
            q.push_back(y[i]);
        return q;
    endfunction

    function automatic cnoc_tb_pkg::byte_q_t digit_run(int len);
        cnoc_tb_pkg::byte_q_t q;
        for (int i = 0; i < len; i++)
            q.push_back(cnoc_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        return q;
    endfunction

    // name ending: mostly a digit run, long enough now and then to saturate
    function automatic cnoc_tb_pkg::byte_q_t rand_tail();
        cnoc_tb_pkg::byte_q_t q;
        int                   pick;
        string                marks = "XYMTabc_./:";
        pick = $urandom_range(0, 9);
        if (pick <= 6)
        begin
            q = digit_run(($urandom_range(0, 5) == 0) ? $urandom_range(9, 12)
                                                      : $urandom_range(1, 3));
            if ($urandom_range(0, 2) == 0)
                q.push_back(marks[$urandom_range(0, marks.len() - 1)]);
        end
        else if (pick == 7)
            repeat ($urandom_range(1, 2)) q.push_back(marks[$urandom_range(0, marks.len() - 1)]);
        else if (pick == 9)
            repeat ($urandom_range(1, 2)) q.push_back(8'($urandom_range(1, 255)));
        return q;
    endfunction

    task automatic random_comparison();
        cnoc_tb_pkg::byte_q_t stem;
        cnoc_tb_pkg::byte_q_t na;
        cnoc_tb_pkg::byte_q_t nb;
        cnoc_tb_pkg::byte_q_t none;
        // plain noise now and then
        if ($urandom_range(0, 6) == 0)
        begin
            send_names(none, none, 1'b0, $urandom_range(1, 6));
            return;
        end
        case ($urandom_range(0, 3))
            0: stem = text("");
            1: stem = text("chr");
            2: stem = text("chrUn_");
            default: stem = text("scaffold");
        endcase
        // shared leading digits put the start of the run inside the prefix
        if ($urandom_range(0, 2) == 0)
            stem = join_bytes(stem, digit_run($urandom_range(1, 3)));
        na = join_bytes(stem, rand_tail());
        if ($urandom_range(0, 7) == 0)
            nb = na;
        else
            nb = join_bytes(stem, rand_tail());
        send_names(na, nb, $urandom_range(0, 9) != 0,
                   ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
    endtask

    initial
    begin
        cnoc_tb_pkg::byte_q_t none;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: saturation on both sides with no terminator, equal names,
        // numeric order, run begun in the prefix, digit borders, junk after a
        // decision, run not ending its name, byte extremes
        send_names(text("5000000000"), text("6000000000"), 1'b0, 0);
        send_names(text("1"), text("1"), 1'b1, 0);
        send_names(text("2"), text("10"), 1'b1, 0);
        send_names(text("19"), text("10"), 1'b1, 0);
        send_names(text("/"), text("0"), 1'b1, 0);
        send_names(text("A"), text("B"), 1'b1, 2);
        send_names(text("1x"), text("2"), 1'b1, 0);
        send_names(text("\377"), none, 1'b1, 0);
        send_names(none, text("\377"), 1'b0, 0);

        while (pairs_sent < ITEM_TARGET)
            random_comparison();
        s_axis_tvalid <= 1'b0;

        while (board.pending_orders.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("compared %0d name pairs over %0d byte pairs", board.compared, pairs_sent);
        $display("%0d ordered by number, %0d with a saturated number, %0d mismatches",
                 board.numeric_seen, board.saturated_seen, board.mismatches);
        if (board.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
